FILE: sv/apfm_pkg.sv
// Shared types and constants for the averaged period frequency meter.
package apfm_pkg;

    // Fixed field and register widths
    localparam int PERIOD_W    = 16;
    localparam int MEAN_W      = 16;
    localparam int CLOCK_W     = 28;
    localparam int PRESCALE_W  = 17;
    localparam int FREQ_W      = 38;
    localparam int PRODUCT_W   = PRESCALE_W + MEAN_W;
    localparam int REM_W       = PRODUCT_W + 1;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = CLOCK_W;

    // Register reset values
    localparam logic [CLOCK_W-1:0]    CLOCK_RESET    = 28'd170000000;
    localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = 17'd170;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CLOCK_HZ = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESCALE = 1'd1;

    // Serial step counts of the arithmetic unit
    localparam int STEP_W    = 6;
    localparam int MEAN_STEPS = MEAN_W;
    localparam int MUL_STEPS  = MEAN_W;
    localparam int DIV_STEPS  = FREQ_W;

    // Arithmetic unit sequencer states
    typedef enum logic [2:0] {
        CALC_IDLE,
        CALC_MEAN,
        CALC_MUL,
        CALC_DIV,
        CALC_DONE
    } calc_state_t;

    // Status of the arithmetic unit towards the accumulator
    typedef struct packed {
        logic idle;
        logic result_valid;
    } calc_status_t;

endpackage

FILE: sv/apfm_calc.sv
// Bit-serial arithmetic unit: block mean, divisor product and frequency quotient.
module apfm_calc
    import apfm_pkg::*;
#(
    parameter int SAMPLES_PER_BLOCK = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [MEAN_W+$clog2(SAMPLES_PER_BLOCK)-1:0] block_sum,
    input  logic [CLOCK_W-1:0]            clock_hz,
    input  logic [PRESCALE_W-1:0]         prescale,
    input  logic                          out_stall,
    output calc_status_t                  status,
    output logic [FREQ_W-1:0]             freq,
    output logic [MEAN_W-1:0]             mean
);

    localparam int CNT_W = $clog2(SAMPLES_PER_BLOCK);
    localparam int SUM_W = MEAN_W + CNT_W;
    localparam logic [REM_W-1:0] BLOCK_DIVISOR = REM_W'(SAMPLES_PER_BLOCK);

    calc_state_t             state_reg, state_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic [REM_W-1:0]        rem_reg;
    logic [FREQ_W-1:0]       quo_reg;
    logic [PRODUCT_W-1:0]    product_reg;
    logic [MEAN_W-1:0]       mul_bits_reg;
    logic [MEAN_W-1:0]       mean_reg;
    logic [FREQ_W-1:0]       freq_reg;

    logic                    next_bit;
    logic [REM_W-1:0]        divisor_sel;
    logic [REM_W-1:0]        partial;
    logic [REM_W:0]          diff;
    logic                    fits;
    logic [REM_W-1:0]        rem_step;
    logic [FREQ_W-1:0]       numerator;
    logic                    step_last;

    // Shared restoring subtractor: one quotient bit per cycle
    always_comb
    begin
        if (state_reg == CALC_MEAN)
        begin
            next_bit    = quo_reg[MEAN_W-1];
            divisor_sel = BLOCK_DIVISOR;
        end
        else
        begin
            next_bit    = quo_reg[FREQ_W-1];
            divisor_sel = REM_W'(product_reg);
        end
        partial  = {rem_reg[REM_W-2:0], next_bit};
        diff     = {1'b0, partial} - {1'b0, divisor_sel};
        fits     = !diff[REM_W];
        rem_step = fits ? diff[REM_W-1:0] : partial;
    end

    // Scale the clock to millihertz: times 1024 less times 16 less times 8
    assign numerator = (FREQ_W'(clock_hz) << 10) - (FREQ_W'(clock_hz) << 4)
                     - (FREQ_W'(clock_hz) << 3);

    // Next state and outputs of the sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        step_last  = 1'b0;
        case (state_reg)
            CALC_IDLE:
            begin
                step_next = '0;
                if (start)
                begin
                    state_next = CALC_MEAN;
                end
            end
            CALC_MEAN:
            begin
                step_last = (step_reg == STEP_W'(MEAN_STEPS - 1));
                step_next = step_last ? '0 : step_reg + STEP_W'(1);
                if (step_last)
                begin
                    state_next = CALC_MUL;
                end
            end
            CALC_MUL:
            begin
                step_last = (step_reg == STEP_W'(MUL_STEPS - 1));
                step_next = step_last ? '0 : step_reg + STEP_W'(1);
                if (step_last)
                begin
                    state_next = CALC_DIV;
                end
            end
            CALC_DIV:
            begin
                step_last = (step_reg == STEP_W'(DIV_STEPS - 1));
                step_next = step_last ? '0 : step_reg + STEP_W'(1);
                if (step_last)
                begin
                    state_next = CALC_DONE;
                end
            end
            CALC_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = CALC_IDLE;
                end
            end
            default:
            begin
                state_next = CALC_IDLE;
            end
        endcase
        status.idle         = (state_reg == CALC_IDLE);
        status.result_valid = (state_reg == CALC_DONE);
    end

    // Hold the sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CALC_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Advance the serial datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            CALC_IDLE:
            begin
                if (start)
                begin
                    rem_reg <= REM_W'(block_sum[SUM_W-1:MEAN_W]);
                    quo_reg <= FREQ_W'(block_sum[MEAN_W-1:0]);
                end
            end
            CALC_MEAN:
            begin
                rem_reg             <= rem_step;
                quo_reg[MEAN_W-1:0] <= {quo_reg[MEAN_W-2:0], fits};
                if (step_last)
                begin
                    mean_reg     <= {quo_reg[MEAN_W-2:0], fits};
                    mul_bits_reg <= {quo_reg[MEAN_W-2:0], fits};
                    product_reg  <= '0;
                end
            end
            CALC_MUL:
            begin
                product_reg  <= {product_reg[PRODUCT_W-2:0], 1'b0}
                              + (mul_bits_reg[MEAN_W-1] ? PRODUCT_W'(prescale)
                                                        : PRODUCT_W'(0));
                mul_bits_reg <= {mul_bits_reg[MEAN_W-2:0], 1'b0};
                if (step_last)
                begin
                    quo_reg <= numerator;
                    rem_reg <= '0;
                end
            end
            CALC_DIV:
            begin
                rem_reg <= rem_step;
                quo_reg <= {quo_reg[FREQ_W-2:0], fits};
                if (step_last)
                begin
                    // Drop the quotient when the divisor is zero
                    freq_reg <= (product_reg == '0) ? '0
                                                    : {quo_reg[FREQ_W-2:0], fits};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign freq = freq_reg;
    assign mean = mean_reg;

endmodule

FILE: sv/averaged_period_frequency_meter_unit.sv
// Top level: block accumulator, configuration registers and result output.
// Items of a block are taken one per cycle while input is not stalled; the last item of a
// block hands its sum to the bit-serial arithmetic unit, whose result shows after its 16
// mean, 16 multiply and 38 divide steps (the sum loads at the accepting edge). A block end
// stalls input while that unit is busy, so the next block's items are taken while it works
// but its last item waits for the unit to be idle. Reset clears the sum, the count and the
// sequencer, and loads the register defaults.
module averaged_period_frequency_meter_unit
    import apfm_pkg::*;
#(
    parameter int SAMPLES_PER_BLOCK = 16,
    parameter int PERIOD_BITS       = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [PERIOD_W-1:0]    capture_period,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [FREQ_W-1:0]      frequency_millihertz,
    output logic [MEAN_W-1:0]      mean_period,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CNT_W     = $clog2(SAMPLES_PER_BLOCK);
    localparam int USED_BITS = (PERIOD_BITS < PERIOD_W) ? PERIOD_BITS : PERIOD_W;
    localparam int ACC_W     = USED_BITS + CNT_W;
    localparam int SUM_W     = MEAN_W + CNT_W;
    localparam logic [PERIOD_W-1:0] PERIOD_MASK =
        PERIOD_W'((33'd1 << USED_BITS) - 33'd1);

    logic [CLOCK_W-1:0]    clock_reg;
    logic [PRESCALE_W-1:0] prescale_reg;
    logic [ACC_W-1:0]      sum_reg, sum_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [PERIOD_W-1:0]   period_used;
    logic                  block_last;
    logic                  in_accept;
    logic                  calc_start;
    logic [SUM_W-1:0]      block_sum;
    calc_status_t          calc_status;

    // Keep only the configured period bits
    assign period_used = capture_period & PERIOD_MASK;
    assign block_last  = (count_reg == CNT_W'(SAMPLES_PER_BLOCK - 1));

    // Hold input at a block end until the arithmetic unit is free
    assign in_stall   = block_last && !calc_status.idle;
    assign in_accept  = in_valid && !in_stall;
    assign calc_start = in_accept && block_last;
    assign block_sum  = SUM_W'(sum_reg) + SUM_W'(period_used);

    // Accumulate the block, restarting after its last item
    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        if (in_accept)
        begin
            if (block_last)
            begin
                sum_next   = '0;
                count_next = '0;
            end
            else
            begin
                sum_next   = sum_reg + ACC_W'(period_used);
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg    <= CLOCK_RESET;
            prescale_reg <= PRESCALE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_CLOCK_HZ: clock_reg    <= cfg_data;
                CFG_PRESCALE: prescale_reg <= cfg_data[PRESCALE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Bit-serial mean and frequency
    apfm_calc #(
        .SAMPLES_PER_BLOCK (SAMPLES_PER_BLOCK)
    ) u_calc (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (calc_start),
        .block_sum (block_sum),
        .clock_hz  (clock_reg),
        .prescale  (prescale_reg),
        .out_stall (out_stall),
        .status    (calc_status),
        .freq      (frequency_millihertz),
        .mean      (mean_period)
    );

    assign out_valid = calc_status.result_valid;

    // A finished block starts the arithmetic unit and clears the accumulator
    assert property (@(posedge clk) disable iff (!rst_n)
        calc_start |=> (!calc_status.idle && count_reg == '0 && sum_reg == '0))
        else $error("block end did not start the arithmetic unit");

    // A zero mean never gives a non-zero frequency
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && mean_period == '0) |-> (frequency_millihertz == '0))
        else $error("non-zero frequency for a zero mean");

    // Input held back at a block end with no result out finds the arithmetic unit busy
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (block_last && !out_valid |-> !calc_status.idle))
        else $error("input stalled with the arithmetic unit free");

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the averaged period frequency meter.
module testbench;
    import apfm_pkg::*;

    localparam int BLOCK_LEN        = 16;
    localparam int SUM_W            = 20;
    localparam int BLOCKS_PER_PHASE = 13;
    localparam int DRAIN_CYCLES     = 90;
    localparam int HOLD_CYCLES      = 600;
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam logic [63:0] MILLI_PER_HZ = 64'd1000;

    // Period patterns that make up one block
    typedef enum int {
        BLOCK_ZERO,
        BLOCK_TINY,
        BLOCK_FULL,
        BLOCK_SHORT,
        BLOCK_STEADY,
        BLOCK_ANY
    } block_shape_t;

    typedef struct {
        logic [FREQ_W-1:0] freq;
        logic [MEAN_W-1:0] mean;
    } reading_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [PERIOD_W-1:0]    capture_period = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [FREQ_W-1:0]      frequency_millihertz;
    logic [MEAN_W-1:0]      mean_period;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_CLOCK_HZ;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Periods waiting to be offered, and readings waiting to come out
    logic [PERIOD_W-1:0] period_queue[$];
    reading_t            awaited_readings[$];
    int                  queued_total = 0;

    // Predictor state, owned by the observing process
    logic [SUM_W-1:0]      block_sum = '0;
    int                    block_fill = 0;
    logic [CLOCK_W-1:0]    meter_hz = CLOCK_RESET;
    logic [PRESCALE_W-1:0] meter_prescale = PRESCALE_RESET;

    int offered_count = 0;
    int taken_count = 0;
    int readings_checked = 0;
    int zero_freq_readings = 0;
    int register_writes = 0;
    int mismatch_count = 0;
    int stuck_cycles = 0;

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    int   hold_count = 0;

    averaged_period_frequency_meter_unit #(
        .SAMPLES_PER_BLOCK (BLOCK_LEN),
        .PERIOD_BITS       (PERIOD_W)
    ) dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .capture_period       (capture_period),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .frequency_millihertz (frequency_millihertz),
        .mean_period          (mean_period),
        .cfg_write            (cfg_write),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Frequency in millihertz for a mean period, zero when the divisor vanishes
    function automatic logic [FREQ_W-1:0] millihertz_for(input logic [MEAN_W-1:0] mean,
                                                         input logic [CLOCK_W-1:0] hz,
                                                         input logic [PRESCALE_W-1:0] presc);
        logic [63:0] divisor;
        logic [63:0] scaled;
        logic [63:0] quotient;
        divisor = 64'(presc);
        divisor = divisor * 64'(mean);
        scaled = 64'(hz);
        scaled = scaled * MILLI_PER_HZ;
        if (divisor == 0)
            return '0;
        quotient = scaled / divisor;
        return quotient[FREQ_W-1:0];
    endfunction

    task automatic queue_period(input logic [PERIOD_W-1:0] value);
        period_queue.push_back(value);
        queued_total++;
    endtask

    // Complete the open block, add whole blocks of random shape, then leave a partial one
    task automatic queue_blocks(input int count);
        block_shape_t        shape;
        logic [PERIOD_W-1:0] level;
        logic [PERIOD_W-1:0] value;
        int                  tail;
        for (int b = 0; b < count; b++)
        begin
            case ($urandom_range(9, 0))
                0: shape = BLOCK_ZERO;
                1: shape = BLOCK_TINY;
                2: shape = BLOCK_FULL;
                3: shape = BLOCK_SHORT;
                4: shape = BLOCK_STEADY;
                default: shape = BLOCK_ANY;
            endcase
            level = PERIOD_W'($urandom);
            for (int i = queued_total % BLOCK_LEN; i < BLOCK_LEN; i++)
            begin
                case (shape)
                    BLOCK_ZERO:   value = '0;
                    BLOCK_TINY:   value = PERIOD_W'($urandom_range(1, 0));
                    BLOCK_FULL:   value = '1;
                    BLOCK_SHORT:  value = PERIOD_W'($urandom_range(40, 1));
                    BLOCK_STEADY: value = level;
                    default:      value = PERIOD_W'($urandom);
                endcase
                queue_period(value);
            end
        end
        tail = $urandom_range(BLOCK_LEN - 1, 1);
        for (int i = 0; i < tail; i++)
            queue_period(PERIOD_W'($urandom));
    endtask

    // Wait until every period is taken and every reading has come, then let the unit drain
    task automatic settle();
        while (!(period_queue.size() == 0 && taken_count == offered_count
                 && awaited_readings.size() == 0))
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic run_phase(input logic [CLOCK_W-1:0] hz, input logic [PRESCALE_W-1:0] presc,
                             input int send_pct, input int stall_pct);
        logic [CFG_DATA_W-1:0] data;
        settle();
        write_register(CFG_CLOCK_HZ, hz);
        // Upper data bits are noise for the prescaler
        data = CFG_DATA_W'($urandom);
        data[PRESCALE_W-1:0] = presc;
        write_register(CFG_PRESCALE, data);
        @(posedge clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        queue_blocks(BLOCKS_PER_PHASE);
    endtask

    // Offer periods from the queue, idling at random; hold a period until it is taken
    always @(negedge clk)
    begin
        if (rst_n && taken_count == offered_count)
        begin
            if (period_queue.size() > 0 && $urandom_range(99, 0) >= send_idle_pct)
            begin
                capture_period <= period_queue.pop_front();
                in_valid       <= 1'b1;
                offered_count  <= offered_count + 1;
            end
            else
            begin
                capture_period <= PERIOD_W'($urandom);
                in_valid       <= 1'b0;
            end
        end
    end

    // Stall the result side at random, or for one long stretch on request
    always @(negedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            out_stall <= 1'b1;
            if (hold_count == HOLD_CYCLES - 1)
                hold_done <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else
            out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end

    // Check readings, predict new ones and track register writes
    always @(posedge clk)
    begin : observe
        reading_t           want;
        logic [SUM_W-1:0]   quotient;
        logic [MEAN_W-1:0]  mean;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                readings_checked++;
                if (frequency_millihertz == '0)
                    zero_freq_readings++;
                if (awaited_readings.size() == 0)
                begin
                    $error("reading with none awaited: frequency_millihertz %0d mean_period %0d",
                           frequency_millihertz, mean_period);
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_readings.pop_front();
                    if (frequency_millihertz !== want.freq)
                    begin
                        $error("frequency_millihertz: expected %0d, got %0d",
                               want.freq, frequency_millihertz);
                        mismatch_count++;
                    end
                    if (mean_period !== want.mean)
                    begin
                        $error("mean_period: expected %0d, got %0d", want.mean, mean_period);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                taken_count <= taken_count + 1;
                block_sum = block_sum + SUM_W'(capture_period);
                block_fill++;
                if (block_fill == BLOCK_LEN)
                begin
                    quotient  = block_sum / SUM_W'(BLOCK_LEN);
                    mean      = quotient[MEAN_W-1:0];
                    want.mean = mean;
                    want.freq = millihertz_for(mean, meter_hz, meter_prescale);
                    awaited_readings.push_back(want);
                    block_sum  = '0;
                    block_fill = 0;
                end
            end
            if (cfg_write)
            begin
                register_writes++;
                if (cfg_index == CFG_CLOCK_HZ)
                    meter_hz = cfg_data[CLOCK_W-1:0];
                else if (cfg_index == CFG_PRESCALE)
                    meter_prescale = cfg_data[PRESCALE_W-1:0];
            end
        end
    end

    // End the run if no handshake completes for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles == WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no item moved for %0d cycles, %0d readings still awaited",
                         WATCHDOG_LIMIT, awaited_readings.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Opening block at the period ceiling, then nine zero periods that open the next block
        for (int i = 0; i < BLOCK_LEN; i++)
            queue_period('1);
        for (int i = 0; i < 9; i++)
            queue_period('0);

        // Register defaults, with one long result-side hold while periods keep coming
        queue_blocks(8 + BLOCKS_PER_PHASE);
        hold_req = 1'b1;
        while (!hold_done)
            @(posedge clk);
        hold_req = 1'b0;

        run_phase(28'd1, 17'd1, 63, 0);
        run_phase('1, 17'd1, 0, 63);
        run_phase(CLOCK_RESET, 17'd65536, 34, 34);
        run_phase('0, '1, 0, 0);
        run_phase(CLOCK_W'($urandom_range(170000000, 1)), '0, 63, 0);
        run_phase(CLOCK_W'($urandom), PRESCALE_W'($urandom), 0, 63);
        run_phase(CLOCK_RESET, PRESCALE_RESET, 34, 34);
        settle();

        $display("Covered %0d periods and %0d block readings (%0d at zero frequency),",
                 taken_count, readings_checked, zero_freq_readings);
        $display("across %0d register writes and four idling mixes.", register_writes);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
sv/apfm_pkg.sv
sv/apfm_calc.sv
sv/averaged_period_frequency_meter_unit.sv
verif/testbench.sv
